>>> rtl/dcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dcr_pkg;
  localparam int PosW  = 24;
  localparam int RestW = 23;
  localparam int DW    = 25;
  localparam int SqW   = 50;
  localparam int LenW  = 25;
  localparam int StrW  = 26;
  localparam int ProdW = DW + StrW;
  localparam int SqrtSteps = LenW;
  localparam int DivSteps  = ProdW;
  localparam logic [RestW-1:0] RestReset = RestW'(2560);

  typedef struct packed {
    logic signed [PosW-1:0] ax;
    logic signed [PosW-1:0] ay;
    logic signed [PosW-1:0] bx;
    logic signed [PosW-1:0] by;
    logic                   mov_a;
    logic                   mov_b;
  } link_t;

  typedef struct packed {
    logic signed [PosW-1:0] ax;
    logic signed [PosW-1:0] ay;
    logic signed [PosW-1:0] bx;
    logic signed [PosW-1:0] by;
    logic                   cut;
  } res_t;

  typedef struct packed {
    link_t                  lk;
    logic [RestW-1:0]       rest;
    logic [SqW-1:0]         rem;
    logic [LenW-1:0]        root;
  } sq_cell_t;

  typedef struct packed {
    link_t                  lk;
    logic                   apply;
    logic                   cut;
    logic                   nx;
    logic                   ny;
    logic [ProdW-1:0]       mx;
    logic [ProdW-1:0]       my;
    logic [ProdW+1:0]       den;
    logic [ProdW+1:0]       remx;
    logic [ProdW+1:0]       remy;
    logic [ProdW-1:0]       qx;
    logic [ProdW-1:0]       qy;
  } dv_cell_t;

  function automatic logic signed [PosW-1:0] sat(input logic signed [ProdW+1:0] v);
    if (v > (ProdW+2)'(signed'(8388607))) begin
      return PosW'(8388607);
    end else if (v < -(ProdW+2)'(signed'(8388608))) begin
      return {1'b1, {(PosW-1){1'b0}}};
    end else begin
      return v[PosW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/dcr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface dcr_link_if;
  import dcr_pkg::*;
  logic valid;
  logic ready;
  logic signed [PosW-1:0] pos_a_x;
  logic signed [PosW-1:0] pos_a_y;
  logic signed [PosW-1:0] pos_b_x;
  logic signed [PosW-1:0] pos_b_y;
  logic moving_a;
  logic moving_b;
  modport source(output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, moving_a, moving_b,
                 input ready);
  modport sink(input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, moving_a, moving_b,
               output ready);
endinterface

interface dcr_res_if;
  import dcr_pkg::*;
  logic valid;
  logic ready;
  logic signed [PosW-1:0] new_a_x;
  logic signed [PosW-1:0] new_a_y;
  logic signed [PosW-1:0] new_b_x;
  logic signed [PosW-1:0] new_b_y;
  logic cut;
  modport source(output valid, new_a_x, new_a_y, new_b_x, new_b_y, cut, input ready);
  modport sink(input valid, new_a_x, new_a_y, new_b_x, new_b_y, cut, output ready);
endinterface
`default_nettype wire

>>> rtl/distance_constraint_relax.sv
`timescale 1ns / 1ps
`default_nettype none
// Distance constraint relaxation for one link per item.
// Write rest_length through cfg_we/cfg_data while idle; reset loads 10.0 px.
// Input items arrive on link_in (valid/ready), one link between two particles
// with Q16.8 positions and pin flags. Results leave on res_out (valid/ready):
// corrected positions and the cut flag, one result per item, in order.
// The block is a pipeline of cells: two stages form dx, dy and their squares,
// 25 square root cells produce the length one bit per cell, one stage forms
// the stretch products, one stage forms the rounding numerators, 51 divider
// cells produce the rounded correction one quotient bit per cell, and a final
// stage adds and saturates.
// Throughput is one item per cycle while res_out is taken.
// When the receiver stalls, the whole pipeline holds and link_in.ready falls;
// an item already shown on res_out stays unchanged until it is taken.
// Reset clears all valid flags and holds link_in.ready low while rst is high.
module distance_constraint_relax (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [dcr_pkg::RestW-1:0] cfg_data,
  dcr_link_if.sink link_in,
  dcr_res_if.source res_out
);
  import dcr_pkg::*;
  localparam int NStg = 2 + SqrtSteps + 2 + DivSteps + 1;

  logic [RestW-1:0] rest;
  logic [NStg-1:0]  vld;
  logic             en;

  assign en = !vld[NStg-1] || res_out.ready;
  assign link_in.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest <= RestReset;
      vld <= '0;
    end else begin
      if (cfg_we) begin
        rest <= cfg_data;
      end
      if (en) begin
        vld <= {vld[NStg-2:0], link_in.valid};
      end
    end
  end

  link_t s0_lk;
  logic signed [DW-1:0] s0_dx;
  logic signed [DW-1:0] s0_dy;
  logic signed [SqW-1:0] s0_sqx;
  logic signed [SqW-1:0] s0_sqy;
  sq_cell_t sq_in;

  always_comb begin
    s0_sqx = s0_dx * s0_dx;
    s0_sqy = s0_dy * s0_dy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_lk <= '{link_in.pos_a_x, link_in.pos_a_y, link_in.pos_b_x, link_in.pos_b_y,
                 link_in.moving_a, link_in.moving_b};
      s0_dx <= DW'(link_in.pos_b_x) - DW'(link_in.pos_a_x);
      s0_dy <= DW'(link_in.pos_b_y) - DW'(link_in.pos_a_y);
      sq_in.lk <= s0_lk;
      sq_in.rest <= rest;
      sq_in.rem <= unsigned'(s0_sqx) + unsigned'(s0_sqy);
      sq_in.root <= '0;
    end
  end

  sq_cell_t sq [SqrtSteps+1];
  assign sq[0] = sq_in;
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sq
    dcr_sqrt_cell u_cell (.clk(clk), .en(en), .step(6'(i)), .d(sq[i]), .q(sq[i+1]));
  end

  sq_cell_t sqo;
  logic signed [StrW-1:0] strv;
  logic tear;
  dv_cell_t dv_in;
  logic signed [DW-1:0] ddx;
  logic signed [DW-1:0] ddy;
  logic signed [ProdW-1:0] px;
  logic signed [ProdW-1:0] py;
  always_comb begin
    sqo = sq[SqrtSteps];
    strv = signed'(StrW'(sqo.root)) - signed'(StrW'(sqo.rest));
    tear = (strv > 0) &&
           ({strv, 2'b00} >= (StrW+2)'(sqo.rest) * (StrW+2)'(3));
    ddx = DW'(sqo.lk.bx) - DW'(sqo.lk.ax);
    ddy = DW'(sqo.lk.by) - DW'(sqo.lk.ay);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px <= ProdW'(ddx) * ProdW'(strv);
      py <= ProdW'(ddy) * ProdW'(strv);
      dv_in.lk <= sqo.lk;
      dv_in.apply <= !tear && (sqo.root != '0);
      dv_in.cut <= tear;
      dv_in.den <= (sqo.lk.mov_a && sqo.lk.mov_b) ? (ProdW+2)'(sqo.root) << 2
                                                    : (ProdW+2)'(sqo.root) << 1;
      dv_in.qx <= '0;
      dv_in.qy <= '0;
      dv_in.mx <= '0;
      dv_in.my <= '0;
      dv_in.nx <= 1'b0;
      dv_in.ny <= 1'b0;
      dv_in.remx <= '0;
      dv_in.remy <= '0;
    end
  end

  // The numerator is 2*|d*stretch| + den/2, so the quotient rounds half away from zero.
  dv_cell_t dv0;
  logic [ProdW-1:0] amx;
  logic [ProdW-1:0] amy;
  always_comb begin
    dv0 = dv_in;
    amx = px[ProdW-1] ? ProdW'(-px) : ProdW'(px);
    amy = py[ProdW-1] ? ProdW'(-py) : ProdW'(py);
    dv0.nx = px[ProdW-1];
    dv0.ny = py[ProdW-1];
    dv0.mx = {amx[ProdW-2:0], 1'b0} + ProdW'(dv_in.den >> 1);
    dv0.my = {amy[ProdW-2:0], 1'b0} + ProdW'(dv_in.den >> 1);
  end

  dv_cell_t dv [DivSteps+1];
  dv_cell_t dvs;
  always_ff @(posedge clk) begin
    if (en) begin
      dvs <= dv0;
    end
  end
  assign dv[0] = dvs;

  for (genvar i = 0; i < DivSteps; i++) begin : g_dv
    dcr_div_cell u_cell (.clk(clk), .en(en), .d(dv[i]), .q(dv[i+1]));
  end

  dv_cell_t dvo;
  logic signed [ProdW+1:0] cxs;
  logic signed [ProdW+1:0] cys;
  res_t res;
  always_comb begin
    dvo = dv[DivSteps];
    cxs = dvo.nx ? -(ProdW+2)'(dvo.qx) : (ProdW+2)'(dvo.qx);
    cys = dvo.ny ? -(ProdW+2)'(dvo.qy) : (ProdW+2)'(dvo.qy);
    res.ax = dvo.lk.ax;
    res.ay = dvo.lk.ay;
    res.bx = dvo.lk.bx;
    res.by = dvo.lk.by;
    res.cut = dvo.cut;
    if (dvo.apply && dvo.lk.mov_a) begin
      res.ax = sat((ProdW+2)'(dvo.lk.ax) + cxs);
      res.ay = sat((ProdW+2)'(dvo.lk.ay) + cys);
    end
    if (dvo.apply && dvo.lk.mov_b) begin
      res.bx = sat((ProdW+2)'(dvo.lk.bx) - cxs);
      res.by = sat((ProdW+2)'(dvo.lk.by) - cys);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_out.new_a_x <= res.ax;
      res_out.new_a_y <= res.ay;
      res_out.new_b_x <= res.bx;
      res_out.new_b_y <= res.by;
      res_out.cut <= res.cut;
    end
  end
  assign res_out.valid = vld[NStg-1];
endmodule
`default_nettype wire

>>> rtl/dcr_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module dcr_sqrt_cell (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [5:0]        step,
  input  wire dcr_pkg::sq_cell_t d,
  output dcr_pkg::sq_cell_t      q
);
  import dcr_pkg::*;
  logic [SqW-1:0] trial;
  logic [SqW-1:0] rbits;
  logic [SqW-1:0] bitv;
  sq_cell_t nxt;

  // One digit of the restoring square root: root holds the upper result bits.
  always_comb begin
    nxt = d;
    bitv = SqW'(1) << (2 * (SqrtSteps - 1 - int'(step)));
    rbits = SqW'(d.root) << (2 * (SqrtSteps - int'(step)));
    trial = rbits + bitv;
    nxt.root = d.root << 1;
    if (d.rem >= trial) begin
      nxt.rem = d.rem - trial;
      nxt.root[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/dcr_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module dcr_div_cell (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire dcr_pkg::dv_cell_t d,
  output dcr_pkg::dv_cell_t      q
);
  import dcr_pkg::*;
  dv_cell_t nxt;
  logic [ProdW+1:0] sx;
  logic [ProdW+1:0] sy;

  // One quotient bit for each axis: the next numerator bit moves into the remainder.
  always_comb begin
    nxt = d;
    sx = {d.remx[ProdW:0], d.mx[ProdW-1]};
    sy = {d.remy[ProdW:0], d.my[ProdW-1]};
    nxt.mx = d.mx << 1;
    nxt.my = d.my << 1;
    nxt.qx = d.qx << 1;
    nxt.qy = d.qy << 1;
    nxt.remx = sx;
    nxt.remy = sy;
    if (sx >= d.den) begin
      nxt.remx = sx - d.den;
      nxt.qx[0] = 1'b1;
    end
    if (sy >= d.den) begin
      nxt.remy = sy - d.den;
      nxt.qy[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule
`default_nettype wire
